// ===== hw/rtl/smbstw_pkg.sv =====
// Package for the SMBIOS structure table walker.
// Holds walk phases, record layout, error and register codes.
// No dependencies.
package smbstw_pkg;

  localparam int MAX_STRINGS_DEF = 32;
  localparam int OUT_DEPTH       = 4;
  localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_TABLE_BYTES     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STRUCTURE_TOTAL = 1'b1;

  localparam logic KIND_STRUCT = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_FMT_BEYOND     = 2'd1;
  localparam logic [1:0] ERR_FMT_SHORT      = 2'd2;
  localparam logic [1:0] ERR_UNFORMED_BEYOND = 2'd3;

  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_FORMATTED = 2'd1,
    PH_STRINGS   = 2'd2,
    PH_TAIL      = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  code;
    logic [15:0] index;
    logic [7:0]  stype;
    logic [15:0] handle;
    logic [7:0]  flen;
    logic [5:0]  count;
    logic        ovf;
    logic        last;
  } rec_t;

endpackage

// ===== hw/rtl/smbios_structure_table_walker.sv =====
// A record is registered into the 4-entry output queue as its last byte is taken.
// One table byte per cycle while in_tready is high; a byte that ends a structure
//   with under six bytes left yields two records; out_tready drains one per cycle.
// in_tready drops only while fewer than two queue slots are free.
// Reset (rst_n low, synchronous): walk state to header phase, queue empty,
//   table_bytes = 1, structure_total = 0.
module smbios_structure_table_walker
  import smbstw_pkg::*;
#(
  parameter int MAX_STRINGS = MAX_STRINGS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // byte stream in
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] table_byte
  // record stream out
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] error_code, [17:2] structure_index, [25:18] structure_type,
  // [41:26] structure_handle, [49:42] formatted_length, [55:50] string_count,
  // [56] strings_overflow, [63:57] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // [0] record_kind
  output logic                   out_tlast   // last_result
);

  localparam logic [5:0] SEEN_MAX = 6'(MAX_STRINGS);

  // configuration
  logic [15:0] tbl_r, total_r;

  // walk state
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] done_r, done_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] handle_r, handle_nxt;
  logic        prevz_r, prevz_nxt;
  logic [5:0]  seen_r, seen_nxt;
  logic        stop_r, stop_nxt;
  logic        ovf_r, ovf_nxt;

  // output queue
  rec_t                 q_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;

  logic        in_fire, out_fire, active, fail, ended;
  logic [1:0]  push_n;
  rec_t        rec0, rec1;
  logic [15:0] left, pos_inc, left_inc;
  logic [7:0]  b;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready  = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign b = in_tdata;

  // bytes remaining, taken as zero once the position passes the table end
  assign left     = (pos_r >= tbl_r) ? 16'd0 : tbl_r - pos_r;
  assign pos_inc  = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;
  assign left_inc = (pos_inc >= tbl_r) ? 16'd0 : tbl_r - pos_inc;
  assign active   = in_fire && !stop_r && (done_r < total_r);

  always_comb begin
    pos_nxt    = pos_r;
    done_nxt   = done_r;
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    handle_nxt = handle_r;
    prevz_nxt  = prevz_r;
    seen_nxt   = seen_r;
    stop_nxt   = stop_r;
    ovf_nxt    = ovf_r;
    push_n     = 2'd0;
    fail       = 1'b0;
    ended      = 1'b0;
    rec0       = '0;
    rec1       = '0;
    rec0.index = done_r;
    if (active) begin
      case (phase_r)
        PH_HEADER: begin
          case (off_r)
            8'd0: begin
              if (left < 16'd6) begin
                fail      = 1'b1;
                rec0.code = ERR_FMT_BEYOND;
              end else begin
                type_nxt = b;
              end
            end
            8'd1: begin
              len_nxt = b;
              if ({1'b0, left} < ({9'd0, b} + 17'd1)) begin
                fail      = 1'b1;
                rec0.code = ERR_FMT_BEYOND;
              end else if (b < 8'd4) begin
                fail      = 1'b1;
                rec0.code = ERR_FMT_SHORT;
              end
            end
            8'd2:    handle_nxt = {8'h00, b};
            default: handle_nxt = {b, handle_r[7:0]};
          endcase
          if (fail) begin
            // report header bytes taken so far, then stop the walk
            rec0.kind   = KIND_ERROR;
            rec0.stype  = type_nxt;
            rec0.flen   = len_nxt;
            rec0.handle = handle_nxt;
            rec0.last   = 1'b1;
            push_n      = 2'd1;
            stop_nxt    = 1'b1;
          end else begin
            pos_nxt = pos_inc;
            if (off_r >= 8'd3) begin
              if (len_r <= 8'd4) begin
                phase_nxt = PH_STRINGS;
                off_nxt   = 8'd0;
              end else begin
                phase_nxt = PH_FORMATTED;
                off_nxt   = 8'd4;
              end
            end else begin
              off_nxt = off_r + 8'd1;
            end
          end
        end
        PH_FORMATTED: begin
          pos_nxt = pos_inc;
          if (({1'b0, off_r} + 9'd1) >= {1'b0, len_r}) begin
            phase_nxt = PH_STRINGS;
            off_nxt   = 8'd0;
          end else begin
            off_nxt = off_r + 8'd1;
          end
        end
        default: begin
          // string set: count string starts, end on two zero bytes in a row
          if (phase_r == PH_STRINGS) begin
            if (b != 8'd0) begin
              if (prevz_r) begin
                if (seen_r >= SEEN_MAX) begin
                  ovf_nxt   = 1'b1;
                  phase_nxt = PH_TAIL;
                end else begin
                  seen_nxt = seen_r + 6'd1;
                end
              end
              prevz_nxt = 1'b0;
            end else if (prevz_r) begin
              if (off_r == 8'd0) phase_nxt = PH_TAIL;
              else ended = 1'b1;
            end else begin
              prevz_nxt = 1'b1;
            end
          end else begin
            if (b == 8'd0 && prevz_r) ended = 1'b1;
            else prevz_nxt = (b == 8'd0);
          end
          off_nxt = 8'd1;
          pos_nxt = pos_inc;
          rec0.stype  = type_r;
          rec0.flen   = len_r;
          rec0.handle = handle_r;
          if (ended) begin
            rec0.kind  = KIND_STRUCT;
            rec0.code  = ERR_NONE;
            rec0.count = seen_r;
            rec0.ovf   = ovf_r;
            done_nxt   = done_r + 16'd1;
            phase_nxt  = PH_HEADER;
            off_nxt    = 8'd0;
            type_nxt   = 8'd0;
            len_nxt    = 8'd0;
            handle_nxt = 16'd0;
            prevz_nxt  = 1'b1;
            seen_nxt   = 6'd0;
            ovf_nxt    = 1'b0;
            if ((done_nxt < total_r) && (left_inc < 16'd6)) begin
              // no room left for the next structure
              rec1.kind  = KIND_ERROR;
              rec1.code  = ERR_FMT_BEYOND;
              rec1.index = done_nxt;
              rec1.last  = 1'b1;
              push_n     = 2'd2;
              stop_nxt   = 1'b1;
            end else begin
              rec0.last = 1'b1;
              push_n    = 2'd1;
            end
          end else if (left_inc == 16'd0) begin
            rec0.kind = KIND_ERROR;
            rec0.code = ERR_UNFORMED_BEYOND;
            rec0.last = 1'b1;
            push_n    = 2'd1;
            stop_nxt  = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r    <= 16'd1;
      total_r  <= 16'd0;
      pos_r    <= '0;
      done_r   <= '0;
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      type_r   <= '0;
      len_r    <= '0;
      handle_r <= '0;
      prevz_r  <= 1'b1;
      seen_r   <= '0;
      stop_r   <= 1'b0;
      ovf_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TABLE_BYTES:     tbl_r   <= cfg_wdata;
          REG_STRUCTURE_TOTAL: total_r <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      done_r   <= done_nxt;
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      handle_r <= handle_nxt;
      prevz_r  <= prevz_nxt;
      seen_r   <= seen_nxt;
      stop_r   <= stop_nxt;
      ovf_r    <= ovf_nxt;
      wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(push_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      cnt_r <= cnt_r + OUT_CNT_W'(push_n) - OUT_CNT_W'(out_fire);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= rec0;
    if (push_n == 2'd2) q_r[wr_ptr_r + OUT_PTR_W'(1)] <= rec1;
  end

  rec_t head;
  assign head      = q_r[rd_ptr_r];
  assign out_tdata = {7'd0, head.ovf, head.count, head.flen, head.handle,
                      head.stype, head.index, head.code};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("record queue count beyond depth");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("walk restarted after an error");

  a_no_push_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> (push_n == 2'd0))
    else $error("record produced after the walk stopped");

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    ((push_n != 2'd0) && rec0.kind == KIND_ERROR) |=> stop_r)
    else $error("error record without stopping the walk");

  a_pair_ends_err: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (rec0.kind == KIND_STRUCT && rec1.kind == KIND_ERROR))
    else $error("record pair is not structure then error");

endmodule

// ===== tb/smbios_structure_table_walker_test.sv =====
// Self-checking bench for smbios_structure_table_walker: streams table bytes, predicts records.
// A short scripted walk comes first, then random well-formed structures, then one terminal error.
// Depends on smbstw_pkg and the walker RTL only.
module smbios_structure_table_walker_test;
  import smbstw_pkg::*;

  // Nothing accepted on any port for this many cycles means the block hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last record before a register write or the verdict.
  localparam int SETTLE_CYCLES  = 8;
  // Long receiver hold-off, long enough to fill the 4-entry record queue.
  localparam int PRESS_CYCLES   = 200;
  localparam int ITEM_GOAL      = 800;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_RECORD} chk_t;
  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;
  typedef enum int {
    END_SHORT_START, END_LENGTH_BEYOND, END_LENGTH_SHORT, END_UNFORMED_BEYOND,
    END_AFTER_RECORD
  } finale_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_ADDR_W-1:0]    reg_sel;
    logic [15:0]              value;   // register value, or the table byte in [7:0]
    chk_t                     chk;
    rec_t                     rec;     // typed record for CHK_RECORD rows
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;   // [7:0] table_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] error_code, [17:2] structure_index, [25:18] structure_type,
  // [41:26] structure_handle, [49:42] formatted_length, [55:50] string_count,
  // [56] strings_overflow
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;          // [0] record_kind
  logic                   out_tlast;

  smbios_structure_table_walker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Walker image: registers and walk state as the block should hold them.
  int          table_limit = 1;
  int          walk_target = 0;
  int          byte_pos = 0;
  int          done_count = 0;
  phase_t      walk_ph = PH_HEADER;
  int          offset = 0;
  logic [7:0]  held_type = '0;
  logic [7:0]  held_len = '0;
  logic [15:0] held_handle = '0;
  logic        prev_zero = 1'b1;
  int          strings_found = 0;
  logic        strings_over = 1'b0;
  logic        walk_halted = 1'b0;

  rec_t pending_records[$];
  int   faults = 0;
  int   items_fed = 0;
  int   quiet = 0;
  bit   calm = 1'b0;
  bit   press_request = 1'b0;
  bit   press_taken = 1'b0;
  int   press_left = 0;

  // Scripted opening walk. Bytes before the first structure_total write are ignored.
  script_row_t script [0:21] = '{
    '{ROW_BYTE,  1'b0,                16'h00FF, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_SILENT,  '0},
    '{ROW_WRITE, REG_TABLE_BYTES,     16'hFFFF, CHK_PREDICT, '0},
    '{ROW_WRITE, REG_STRUCTURE_TOTAL, 16'd2,    CHK_PREDICT, '0},
    // all-ones header, minimum length, empty string set (zero first unformed byte)
    '{ROW_BYTE,  1'b0,                16'h00FF, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h0004, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h00FF, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h00FF, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_RECORD,
      '{KIND_STRUCT, ERR_NONE, 16'd0, 8'hFF, 16'hFFFF, 8'd4, 6'd0, 1'b0, 1'b1}},
    // zero type, one formatted byte, two strings
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0005, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0034, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0012, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h00AA, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0041, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0042, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_PREDICT, '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_PREDICT, '0},
    // walk complete: further bytes give nothing
    '{ROW_BYTE,  1'b0,                16'h0055, CHK_SILENT,  '0},
    '{ROW_BYTE,  1'b0,                16'h0000, CHK_SILENT,  '0}
  };

  function automatic int bytes_remaining();
    return (byte_pos >= table_limit) ? 0 : table_limit - byte_pos;
  endfunction

  task automatic next_position();
    if (byte_pos < 65535) byte_pos++;
  endtask

  task automatic start_structure();
    walk_ph       = PH_HEADER;
    offset        = 0;
    held_type     = '0;
    held_len      = '0;
    held_handle   = '0;
    prev_zero     = 1'b1;
    strings_found = 0;
    strings_over  = 1'b0;
  endtask

  // Error record from whatever header bytes are held; the walk stops for good.
  function automatic rec_t halt_record(input logic [1:0] code);
    rec_t r;
    r = '{KIND_ERROR, code, done_count[15:0], held_type, held_handle, held_len,
          6'd0, 1'b0, 1'b0};
    walk_halted = 1'b1;
    return r;
  endfunction

  // Advance the walk by one table byte; return the records it causes (0..2).
  task automatic walk_table_byte(input logic [7:0] b, output int n,
                                 output rec_t r0, output rec_t r1);
    logic ended;
    n     = 0;
    ended = 1'b0;
    r0    = '0;
    r1    = '0;
    if (walk_halted || done_count >= walk_target) return;

    if (walk_ph == PH_HEADER) begin
      case (offset)
        0: begin
          // Table too short for another structure: this byte is not consumed.
          if (bytes_remaining() < 6) begin
            r0 = halt_record(ERR_FMT_BEYOND);
            n  = 1;
          end else begin
            held_type = b;
          end
        end
        1: begin
          held_len = b;
          // Beyond-table check wins over the too-short check.
          if (bytes_remaining() < int'(b) + 1) begin
            r0 = halt_record(ERR_FMT_BEYOND);
            n  = 1;
          end else if (b < 8'd4) begin
            r0 = halt_record(ERR_FMT_SHORT);
            n  = 1;
          end
        end
        2: held_handle[7:0] = b;
        default: held_handle[15:8] = b;
      endcase
      if (n != 0) begin
        r0.last = 1'b1;
        return;
      end
      next_position();
      if (offset >= 3) begin
        if (held_len <= 8'd4) begin
          walk_ph = PH_STRINGS;
          offset  = 0;
        end else begin
          walk_ph = PH_FORMATTED;
          offset  = 4;
        end
      end else begin
        offset++;
      end
      return;
    end

    if (walk_ph == PH_FORMATTED) begin
      next_position();
      if (offset + 1 >= int'(held_len)) begin
        walk_ph = PH_STRINGS;
        offset  = 0;
      end else begin
        offset = (offset + 1) & 8'hFF;
      end
      return;
    end

    if (walk_ph == PH_STRINGS) begin
      if (b != 8'h00) begin
        if (prev_zero) begin
          // A string past the limit: stop counting and just hunt for the end.
          if (strings_found >= MAX_STRINGS_DEF) begin
            strings_over = 1'b1;
            walk_ph      = PH_TAIL;
          end else begin
            strings_found++;
          end
        end
        prev_zero = 1'b0;
      end else if (prev_zero) begin
        // Zero right at the start means an empty set; still needs a double zero.
        if (offset == 0) walk_ph = PH_TAIL;
        else ended = 1'b1;
      end else begin
        prev_zero = 1'b1;
      end
    end else begin
      if (b == 8'h00 && prev_zero) ended = 1'b1;
      else prev_zero = (b == 8'h00);
    end
    offset = 1;
    next_position();

    if (ended) begin
      r0 = '{KIND_STRUCT, ERR_NONE, done_count[15:0], held_type, held_handle, held_len,
             strings_found[5:0], strings_over, 1'b0};
      n  = 1;
      done_count++;
      start_structure();
      // No room for the next structure: error rides on the same byte.
      if (done_count < walk_target && bytes_remaining() < 6) begin
        r1 = halt_record(ERR_FMT_BEYOND);
        n  = 2;
      end
    end else if (bytes_remaining() == 0) begin
      r0 = halt_record(ERR_UNFORMED_BEYOND);
      n  = 1;
    end
    if (n == 1) r0.last = 1'b1;
    else if (n == 2) r1.last = 1'b1;
  endtask

  function automatic string show(input rec_t r);
    return $sformatf("kind %0d code %0d index %0d type %02h handle %04h len %0d count %0d ovf %0d last %0d",
                     r.kind, r.code, r.index, r.stype, r.handle, r.flen, r.count, r.ovf,
                     r.last);
  endfunction

  // Offer one byte, with random gaps unless calm, hold it until taken, then update the image.
  task automatic send_byte(input logic [7:0] b, input chk_t chk = CHK_PREDICT,
                           input rec_t typed = '0);
    int   n;
    rec_t r0;
    rec_t r1;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    if (!walk_halted && done_count < walk_target) items_fed++;
    walk_table_byte(b, n, r0, r1);
    case (chk)
      CHK_PREDICT: begin
        if (n > 0) pending_records.push_back(r0);
        if (n > 1) pending_records.push_back(r1);
      end
      CHK_RECORD: pending_records.push_back(typed);
      default: ;
    endcase
  endtask

  // Drop valid, drain every expected record, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Call only after settle(): registers change while the walker is idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val[15:0];
    @(posedge clk);
    if (idx == REG_TABLE_BYTES) table_limit = val & 16'hFFFF;
    else walk_target = val & 16'hFFFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One well-formed structure: header, formatted filler, string set.
  // With no strings, junk stands for random tail bytes after the empty-set zero.
  task automatic send_structure(input int len, input int nstr, input int junk);
    send_byte(8'($urandom_range(255)));
    send_byte(8'(len));
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    repeat (len - 4) send_byte(8'($urandom_range(255)));
    if (nstr == 0) begin
      send_byte(8'h00);
      for (int j = 0; j < junk; j++) begin
        send_byte(8'($urandom_range(1, 255)));
        // single zeros between junk bytes keep the tail open
        if (j < junk - 1 && $urandom_range(1) == 1) send_byte(8'h00);
      end
      if (junk > 0) send_byte(8'h00);
    end else begin
      for (int s = 0; s < nstr; s++) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)));
        send_byte(8'h00);
      end
    end
    send_byte(8'h00);
  endtask

  // Receiver: random back-pressure, one long hold-off on request, none while calm.
  always @(negedge clk) begin
    if (press_request && !press_taken) begin
      press_taken = 1'b1;
      press_left  = PRESS_CYCLES;
    end
    if (press_left > 0) begin
      press_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Compare each accepted record with the oldest expectation.
  always @(posedge clk) begin : check_records
    rec_t got;
    rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[1:0], out_tdata[17:2], out_tdata[25:18],
              out_tdata[41:26], out_tdata[49:42], out_tdata[55:50], out_tdata[56],
              out_tlast};
      if (pending_records.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected record: %s", show(got));
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= 10) begin
            $display("record mismatch");
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("smbios_structure_table_walker_test NOT OK");
      $finish;
    end
  end

  initial begin
    int      add;
    int      sel;
    int      len;
    int      nstr;
    int      phase_no;
    int      base;
    finale_t finale;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Scripted walk from reset settings.
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        send_byte(script[i].value[7:0], script[i].chk, script[i].rec);
      end
    end

    // Random walk: raise structure_total per phase and feed exactly that many
    // structures, then a few bytes the finished walk must ignore. Always run
    // through the calm phase and the hold-off phase; leave early if the walk stops.
    phase_no = 0;
    while ((items_fed < ITEM_GOAL || phase_no < 3) && !walk_halted) begin
      settle();
      calm = (phase_no == 1);
      add  = (phase_no == 2) ? 10 : $urandom_range(3, 10);
      write_reg(REG_STRUCTURE_TOTAL, (walk_target + add > 65535) ? 65535 : walk_target + add);
      if ($urandom_range(3) == 0)
        write_reg(REG_TABLE_BYTES, $urandom_range(byte_pos + 8000, 65535));
      if (phase_no == 2) press_request = 1'b1;
      repeat (add) begin
        sel = $urandom_range(99);
        if (sel < 5) len = $urandom_range(200, 255);
        else if (sel < 30) len = $urandom_range(13, 64);
        else len = $urandom_range(4, 12);
        nstr = ($urandom_range(99) < 6) ? $urandom_range(30, 40) : $urandom_range(0, 4);
        send_structure(len, nstr, $urandom_range(0, 3));
      end
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
      phase_no++;
    end

    // An error stops the walk for good, so exactly one kind ends the run.
    settle();
    calm = 1'b0;
    write_reg(REG_STRUCTURE_TOTAL, 16'hFFFF);
    base   = byte_pos;
    finale = finale_t'($urandom_range(4));
    case (finale)
      END_SHORT_START: begin
        write_reg(REG_TABLE_BYTES, 1);
        send_byte(8'($urandom_range(255)));
      end
      END_LENGTH_BEYOND: begin
        write_reg(REG_TABLE_BYTES, base + 10);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(9, 255)));
      end
      END_LENGTH_SHORT: begin
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(0, 3)));
      end
      END_UNFORMED_BEYOND: begin
        write_reg(REG_TABLE_BYTES, base + 8);
        send_byte(8'($urandom_range(255)));
        send_byte(8'd4);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        repeat (4) send_byte(8'($urandom_range(1, 255)));
      end
      default: begin
        // record and table-end error from the same closing byte
        write_reg(REG_TABLE_BYTES, base + 6 + $urandom_range(0, 5));
        send_structure(4, 0, 0);
      end
    endcase
    repeat (6) send_byte(8'($urandom_range(255)));

    settle();
    if (faults == 0 && pending_records.size() == 0) begin
      $display("smbios_structure_table_walker_test OK");
    end else begin
      $display("smbios_structure_table_walker_test NOT OK");
    end
    $finish;
  end

endmodule
